### sv/scsp_pkg.sv
`timescale 1ns / 1ps

package scsp_pkg;

	localparam int LEVEL_COUNT  = 20;
	localparam int SLOT_FACTOR  = 512;
	localparam int HEADER_BYTES = 16;

	localparam int REC_HEAD      = 16;
	localparam int FEATURE_BYTES = 20;
	localparam int CHUNK_BYTES   = 28;

	localparam int FC_W   = 16;
	localparam int CC_W   = 20;
	localparam int ID_W   = 61;
	localparam int OFF_W  = 56;
	localparam int LVL_W  = 5;
	localparam int SLOT_W = 29;
	localparam int ST_W   = 3;
	localparam int TOT_W  = 32;

	// largest record: 16 + 20*65535 + 28*1048575 fits in 25 bits
	localparam int SIZE_W     = 25;
	localparam int SLOT_SHIFT = $clog2(SLOT_FACTOR);
	localparam int Q_W        = SIZE_W - SLOT_SHIFT;
	localparam int CLS_W      = $clog2(Q_W + 1);
	localparam int LVL_IDX_W  = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

	localparam logic [ST_W-1:0] ST_NEW      = 3'd0;
	localparam logic [ST_W-1:0] ST_MIGRATED = 3'd1;
	localparam logic [ST_W-1:0] ST_INPLACE  = 3'd2;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd3;
	localparam logic [ST_W-1:0] ST_DOWNWARD = 3'd4;

	typedef enum logic [2:0] {
		K_OVERFLOW,
		K_NEW,
		K_DOWNWARD,
		K_MIGRATE,
		K_INPLACE
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SIZE,
		S_CLASS,
		S_DISPATCH,
		S_RD_OLD,
		S_WR_OLD,
		S_RD_NEW,
		S_WR_NEW,
		S_LOAD
	} state_t;

	typedef struct packed {
		logic load_in;
		logic calc_size;
		logic calc_class;
		logic rd_old;
		logic wr_old;
		logic rd_new;
		logic wr_new;
		logic load_res;
	} ctrl_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  out_busy;
	} dp_status_t;

endpackage

### sv/scsp_ram.sv
`timescale 1ns / 1ps

module scsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/scsp_ctrl.sv
`timescale 1ns / 1ps

module scsp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  scsp_pkg::dp_status_t  stat,
	output scsp_pkg::ctrl_cmd_t   cmd
);

	scsp_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scsp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			scsp_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = scsp_pkg::S_SIZE;
				end
			end
			scsp_pkg::S_SIZE: begin
				cmd.calc_size = 1'b1;
				state_d       = scsp_pkg::S_CLASS;
			end
			scsp_pkg::S_CLASS: begin
				cmd.calc_class = 1'b1;
				state_d        = scsp_pkg::S_DISPATCH;
			end
			scsp_pkg::S_DISPATCH: begin
				unique case (stat.kind)
					scsp_pkg::K_NEW:     state_d = scsp_pkg::S_RD_NEW;
					scsp_pkg::K_MIGRATE: state_d = scsp_pkg::S_RD_OLD;
					default:             state_d = scsp_pkg::S_LOAD;
				endcase
			end
			scsp_pkg::S_RD_OLD: begin
				cmd.rd_old = 1'b1;
				state_d    = scsp_pkg::S_WR_OLD;
			end
			scsp_pkg::S_WR_OLD: begin
				cmd.wr_old = 1'b1;
				state_d    = scsp_pkg::S_RD_NEW;
			end
			scsp_pkg::S_RD_NEW: begin
				cmd.rd_new = 1'b1;
				state_d    = scsp_pkg::S_WR_NEW;
			end
			scsp_pkg::S_WR_NEW: begin
				cmd.wr_new = 1'b1;
				state_d    = scsp_pkg::S_LOAD;
			end
			scsp_pkg::S_LOAD: begin
				// hold until the output register can take the result
				if (!stat.out_busy) begin
					cmd.load_res = 1'b1;
					state_d      = scsp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = scsp_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### sv/scsp_dp.sv
`timescale 1ns / 1ps

module scsp_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  scsp_pkg::ctrl_cmd_t           cmd,
	output scsp_pkg::dp_status_t          stat,
	input  logic [scsp_pkg::FC_W-1:0]     feature_count,
	input  logic [scsp_pkg::CC_W-1:0]     chunk_count,
	input  logic                          is_new,
	input  logic [scsp_pkg::ID_W-1:0]     current_id,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [scsp_pkg::ID_W-1:0]     segment_id,
	output logic [scsp_pkg::LVL_W-1:0]    level,
	output logic [scsp_pkg::OFF_W-1:0]    offset,
	output logic [scsp_pkg::SLOT_W-1:0]   slot_size,
	output logic [scsp_pkg::ST_W-1:0]     status
);

	logic [scsp_pkg::FC_W-1:0]   fc_q;
	logic [scsp_pkg::CC_W-1:0]   cc_q;
	logic                        new_q;
	logic [scsp_pkg::ID_W-1:0]   cur_q;
	logic [scsp_pkg::SIZE_W-1:0] size_q;
	logic [scsp_pkg::CLS_W-1:0]  lvl_q;
	logic [scsp_pkg::OFF_W-1:0]  off_q;

	logic [scsp_pkg::Q_W-1:0]    quot;
	logic [scsp_pkg::CLS_W-1:0]  bitlen;
	logic [scsp_pkg::LVL_W-1:0]  old_lvl;
	logic [scsp_pkg::OFF_W-1:0]  slot_full;
	scsp_pkg::kind_t             kind;

	logic [scsp_pkg::LVL_IDX_W-1:0] lvl_idx;
	logic [scsp_pkg::LVL_IDX_W-1:0] old_idx;
	logic [scsp_pkg::LVL_IDX_W-1:0] tot_addr;
	logic [scsp_pkg::OFF_W-1:0]     vol_rdata;
	logic [scsp_pkg::OFF_W-1:0]     vol_eff;
	logic [scsp_pkg::OFF_W-1:0]     vol_wdata;
	logic [scsp_pkg::TOT_W-1:0]     tot_rdata;
	logic [scsp_pkg::TOT_W-1:0]     tot_eff;
	logic [scsp_pkg::TOT_W-1:0]     tot_wdata;
	logic                           tot_we;
	logic [scsp_pkg::LEVEL_COUNT-1:0] vol_vld_q;
	logic [scsp_pkg::LEVEL_COUNT-1:0] tot_vld_q;

	logic                          out_valid_q;
	logic [scsp_pkg::ID_W-1:0]     res_id_q;
	logic [scsp_pkg::LVL_W-1:0]    res_lvl_q;
	logic [scsp_pkg::OFF_W-1:0]    res_off_q;
	logic [scsp_pkg::SLOT_W-1:0]   res_slot_q;
	logic [scsp_pkg::ST_W-1:0]     res_st_q;

	// input capture, record size and size class
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			fc_q  <= feature_count;
			cc_q  <= chunk_count;
			new_q <= is_new;
			cur_q <= current_id;
		end
		if (cmd.calc_size) begin
			size_q <= scsp_pkg::SIZE_W'(scsp_pkg::REC_HEAD)
				+ scsp_pkg::SIZE_W'(fc_q) * scsp_pkg::SIZE_W'(scsp_pkg::FEATURE_BYTES)
				+ scsp_pkg::SIZE_W'(cc_q) * scsp_pkg::SIZE_W'(scsp_pkg::CHUNK_BYTES);
		end
		if (cmd.calc_class) begin
			lvl_q <= bitlen;
		end
		if (cmd.wr_new) begin
			off_q <= vol_eff;
		end
	end

	assign quot = size_q[scsp_pkg::SIZE_W-1:scsp_pkg::SLOT_SHIFT];

	always_comb begin
		bitlen = '0;
		for (int i = 0; i < scsp_pkg::Q_W; i++) begin
			if (quot[i]) begin
				bitlen = scsp_pkg::CLS_W'(i + 1);
			end
		end
	end

	assign old_lvl   = cur_q[scsp_pkg::ID_W-1:scsp_pkg::OFF_W];
	assign slot_full = scsp_pkg::OFF_W'(scsp_pkg::SLOT_FACTOR) << lvl_q;

	always_comb begin
		priority if (32'(lvl_q) >= scsp_pkg::LEVEL_COUNT) begin
			kind = scsp_pkg::K_OVERFLOW;
		end else if (new_q) begin
			kind = scsp_pkg::K_NEW;
		end else if (32'(old_lvl) > 32'(lvl_q)) begin
			kind = scsp_pkg::K_DOWNWARD;
		end else if (32'(old_lvl) < 32'(lvl_q)) begin
			kind = scsp_pkg::K_MIGRATE;
		end else begin
			kind = scsp_pkg::K_INPLACE;
		end
	end

	// per-level tables: volume end and segment count
	assign lvl_idx  = scsp_pkg::LVL_IDX_W'(lvl_q);
	assign old_idx  = scsp_pkg::LVL_IDX_W'(old_lvl);
	assign tot_addr = (cmd.rd_old || cmd.wr_old) ? old_idx : lvl_idx;

	// entries never written read as their reset value
	assign vol_eff   = vol_vld_q[lvl_idx] ? vol_rdata
		: scsp_pkg::OFF_W'(scsp_pkg::HEADER_BYTES);
	assign tot_eff   = tot_vld_q[tot_addr] ? tot_rdata : '0;
	assign vol_wdata = vol_eff + slot_full;
	assign tot_wdata = cmd.wr_old ? (tot_eff - scsp_pkg::TOT_W'(1))
		: (tot_eff + scsp_pkg::TOT_W'(1));
	assign tot_we    = cmd.wr_old || cmd.wr_new;

	scsp_ram #(
		.WIDTH (scsp_pkg::OFF_W),
		.DEPTH (scsp_pkg::LEVEL_COUNT)
	) u_vol_ram (
		.clk   (clk),
		.we    (cmd.wr_new),
		.waddr (lvl_idx),
		.wdata (vol_wdata),
		.raddr (lvl_idx),
		.rdata (vol_rdata)
	);

	scsp_ram #(
		.WIDTH (scsp_pkg::TOT_W),
		.DEPTH (scsp_pkg::LEVEL_COUNT)
	) u_tot_ram (
		.clk   (clk),
		.we    (tot_we),
		.waddr (tot_addr),
		.wdata (tot_wdata),
		.raddr (tot_addr),
		.rdata (tot_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_vld_q <= '0;
			tot_vld_q <= '0;
		end else begin
			if (cmd.wr_new) begin
				vol_vld_q[lvl_idx] <= 1'b1;
			end
			if (tot_we) begin
				tot_vld_q[tot_addr] <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			res_lvl_q <= scsp_pkg::LVL_W'(lvl_q);
			unique case (kind)
				scsp_pkg::K_OVERFLOW: begin
					res_id_q   <= cur_q;
					res_off_q  <= '0;
					res_slot_q <= '0;
					res_st_q   <= scsp_pkg::ST_OVERFLOW;
				end
				scsp_pkg::K_DOWNWARD: begin
					res_id_q   <= cur_q;
					res_off_q  <= '0;
					res_slot_q <= slot_full[scsp_pkg::SLOT_W-1:0];
					res_st_q   <= scsp_pkg::ST_DOWNWARD;
				end
				scsp_pkg::K_INPLACE: begin
					res_id_q   <= cur_q;
					res_off_q  <= cur_q[scsp_pkg::OFF_W-1:0];
					res_slot_q <= slot_full[scsp_pkg::SLOT_W-1:0];
					res_st_q   <= scsp_pkg::ST_INPLACE;
				end
				scsp_pkg::K_NEW, scsp_pkg::K_MIGRATE: begin
					res_id_q   <= (scsp_pkg::ID_W'(lvl_q) << scsp_pkg::OFF_W)
						| scsp_pkg::ID_W'(off_q);
					res_off_q  <= off_q;
					res_slot_q <= slot_full[scsp_pkg::SLOT_W-1:0];
					res_st_q   <= (kind == scsp_pkg::K_NEW) ? scsp_pkg::ST_NEW
						: scsp_pkg::ST_MIGRATED;
				end
				default: begin
					res_id_q   <= cur_q;
					res_off_q  <= '0;
					res_slot_q <= '0;
					res_st_q   <= scsp_pkg::ST_OVERFLOW;
				end
			endcase
		end
	end

	assign stat.kind     = kind;
	assign stat.out_busy = out_valid_q && !out_ready;

	assign out_valid  = out_valid_q;
	assign segment_id = res_id_q;
	assign level      = res_lvl_q;
	assign offset     = res_off_q;
	assign slot_size  = res_slot_q;
	assign status     = res_st_q;

	a_dec_only_on_migrate: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_old |-> kind == scsp_pkg::K_MIGRATE)
		else $error("old level count touched outside a migration");

	a_dec_then_bump: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_old |=> cmd.wr_old ##1 cmd.rd_new ##1 cmd.wr_new)
		else $error("migration sequence broken");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_res |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");

	a_bump_id_matches_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (res_st_q == scsp_pkg::ST_NEW || res_st_q == scsp_pkg::ST_MIGRATED))
		|-> res_id_q[scsp_pkg::OFF_W-1:0] == res_off_q)
		else $error("allocated id and offset disagree");

endmodule

### sv/size_class_segment_placer.sv
`timescale 1ns / 1ps

// places one segment record per transaction into per-level volumes; the record
// size 16+20f+28c over the slot factor gives the level by bit length, and the
// result is a fresh allocation, a migration, an in-place update, a downward
// move or an error. after acceptance the controller steps through its size and
// class states and a dispatch; a new record then does a read-modify-write of
// the new level's volume end and count rams, and a migration first decrements
// the old level's count, then bumps the new level; other cases go straight to
// the result load. the result sits in an output register, so the next item is
// taken while it waits; a further result stalls only if the previous one is
// still not taken. there is no clearing pass after reset: per-level valid bits
// make unwritten entries read as the header size and zero.
module size_class_segment_placer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [scsp_pkg::FC_W-1:0]     feature_count,
	input  logic [scsp_pkg::CC_W-1:0]     chunk_count,
	input  logic                          is_new,
	input  logic [scsp_pkg::ID_W-1:0]     current_id,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [scsp_pkg::ID_W-1:0]     segment_id,
	output logic [scsp_pkg::LVL_W-1:0]    level,
	output logic [scsp_pkg::OFF_W-1:0]    offset,
	output logic [scsp_pkg::SLOT_W-1:0]   slot_size,
	output logic [scsp_pkg::ST_W-1:0]     status
);

	scsp_pkg::ctrl_cmd_t  cmd;
	scsp_pkg::dp_status_t stat;

	scsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	scsp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.feature_count (feature_count),
		.chunk_count   (chunk_count),
		.is_new        (is_new),
		.current_id    (current_id),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.segment_id    (segment_id),
		.level         (level),
		.offset        (offset),
		.slot_size     (slot_size),
		.status        (status)
	);

endmodule
